### hdl/acpu_pkg.sv
package acpu_pkg;

  localparam int DATA_WORDS = 512;
  localparam int ADDR_W     = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

  localparam logic [1:0] ACT_EXEC  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [3:0] OP_LOAD  = 4'd0;
  localparam logic [3:0] OP_STA   = 4'd1;
  localparam logic [3:0] OP_ADD   = 4'd2;
  localparam logic [3:0] OP_SUB   = 4'd3;
  localparam logic [3:0] OP_MUL   = 4'd4;
  localparam logic [3:0] OP_AND   = 4'd5;
  localparam logic [3:0] OP_OR    = 4'd6;
  localparam logic [3:0] OP_JMP   = 4'd7;
  localparam logic [3:0] OP_HALT  = 4'd8;
  localparam logic [3:0] OP_NOP   = 4'd9;

  typedef struct packed {
    logic [31:0] acc;
    logic [15:0] pc;
    logic        z;
    logic        c;
    logic        n;
    logic        v;
    logic        halt;
  } cpu_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  opcode;
    logic [15:0] operand;
    logic [31:0] write_value;
    logic [15:0] data_address;
  } item_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
  } mem_wr_t;

  function automatic logic addr_in_range(input logic [15:0] a);
    return {1'b0, a} < 17'(DATA_WORDS);
  endfunction

endpackage

### hdl/acpu_dmem.sv
// Data memory, one write and one registered read port, zeroed by a sweep after reset.
module acpu_dmem (
  input  logic                         clk,
  input  logic                         rst,
  input  acpu_pkg::mem_wr_t            wr,
  input  logic                         re,
  input  logic [acpu_pkg::ADDR_W-1:0]  raddr,
  output logic [31:0]                  rdata,
  output logic                         busy
);

  logic [31:0]                 mem [acpu_pkg::DATA_WORDS];
  logic [acpu_pkg::ADDR_W-1:0] clr_addr;
  logic                        clearing;

  assign busy = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == acpu_pkg::ADDR_W'(acpu_pkg::DATA_WORDS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/acpu_exec.sv
// Next-state logic for one item: ALU, PC sequencing, halt, memory write request.
module acpu_exec (
  input  acpu_pkg::cpu_state_t  state,
  input  acpu_pkg::item_t       item,
  input  logic [31:0]           mem_word,
  input  logic [15:0]           program_length,
  output acpu_pkg::cpu_state_t  state_next,
  output logic [31:0]           read_data,
  output acpu_pkg::mem_wr_t     wr
);

  logic [32:0] add_full;
  logic [31:0] add_r;
  logic [31:0] sub_r;
  logic [31:0] mul_r;
  logic        run;

  assign add_full = {1'b0, state.acc} + {1'b0, mem_word};
  assign add_r    = add_full[31:0];
  assign sub_r    = state.acc - mem_word;
  assign mul_r    = state.acc * mem_word;

  assign run = (item.action == acpu_pkg::ACT_EXEC) && !state.halt
               && (state.pc < program_length);

  always_comb begin
    state_next = state;
    read_data  = '0;
    wr.en      = 1'b0;
    wr.addr    = item.operand[acpu_pkg::ADDR_W-1:0];
    wr.data    = state.acc;

    case (item.action)
      acpu_pkg::ACT_EXEC: begin
        if (!state.halt && !run) begin
          state_next.halt = 1'b1;
        end
        if (run) begin
          state_next.pc = state.pc + 16'd1;
          case (item.opcode)
            acpu_pkg::OP_LOAD: begin
              state_next.acc = mem_word;
            end
            acpu_pkg::OP_STA: begin
              wr.en = acpu_pkg::addr_in_range(item.operand);
            end
            acpu_pkg::OP_ADD: begin
              state_next.acc = add_r;
              state_next.c   = add_full[32];
              state_next.v   = ((state.acc[31] ^ add_r[31]) & (mem_word[31] ^ add_r[31]));
            end
            acpu_pkg::OP_SUB: begin
              state_next.acc = sub_r;
              state_next.c   = $signed(mem_word) > $signed(state.acc);
              state_next.v   = 1'b0;
            end
            acpu_pkg::OP_MUL: begin
              state_next.acc = mul_r;
              state_next.c   = 1'b0;
              state_next.v   = 1'b0;
            end
            acpu_pkg::OP_AND: begin
              state_next.acc = state.acc & mem_word;
              state_next.c   = 1'b0;
              state_next.v   = 1'b0;
            end
            acpu_pkg::OP_OR: begin
              state_next.acc = state.acc | mem_word;
              state_next.c   = 1'b0;
              state_next.v   = 1'b0;
            end
            acpu_pkg::OP_JMP: begin
              state_next.pc = item.operand;
            end
            acpu_pkg::OP_HALT: begin
              state_next.halt = 1'b1;
            end
            default: begin
            end
          endcase
          // LOAD and ALU ops refresh Z/N from the new accumulator
          if (item.opcode inside {acpu_pkg::OP_LOAD, acpu_pkg::OP_ADD, acpu_pkg::OP_SUB,
                                  acpu_pkg::OP_MUL, acpu_pkg::OP_AND, acpu_pkg::OP_OR}) begin
            state_next.z = (state_next.acc == 32'd0);
            state_next.n = state_next.acc[31];
          end
        end
      end
      acpu_pkg::ACT_WRITE: begin
        wr.en   = acpu_pkg::addr_in_range(item.data_address);
        wr.addr = item.data_address[acpu_pkg::ADDR_W-1:0];
        wr.data = item.write_value;
      end
      acpu_pkg::ACT_READ: begin
        read_data = mem_word;
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/accumulator_cpu_step.sv
// Accumulator CPU step core. Each input transfer is an execute, data write or data
// read item; each produces exactly one result transfer reporting the accumulator, PC,
// Z/C/N/V flags, halt status and (for reads) the data word. Items flow through a
// two-stage pipeline: the data memory read is issued in the accept cycle and the
// state update happens when the item leaves stage 1 for the result register; one item
// can be accepted every cycle unless the result side stalls. A STORE or write followed
// directly by a read of the same word is forwarded around the memory. After reset
// the data memory is zeroed by a sweep over all DATA_WORDS (512) words, during which
// in_ready stays low; config writes are taken at any time.
module accumulator_cpu_step (
  input  logic               clk,
  input  logic               rst,
  // configuration: program_length
  input  logic               config_write,
  input  logic [15:0]        config_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [3:0]         opcode,
  input  logic [15:0]        operand,
  input  logic signed [31:0] write_value,
  input  logic [15:0]        data_address,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] accumulator,
  output logic [15:0]        program_counter,
  output logic               zero_flag,
  output logic               carry_flag,
  output logic               negative_flag,
  output logic               overflow_flag,
  output logic               halted,
  output logic signed [31:0] read_data
);

  logic [15:0]                 program_length;

  // architectural state, updated when the stage-1 item retires
  acpu_pkg::cpu_state_t        state;
  acpu_pkg::cpu_state_t        state_next;

  // stage 1: item whose memory word is being returned
  logic                        s1_valid;
  acpu_pkg::item_t             s1_item;
  logic                        s1_in_range;
  logic                        s1_adv;

  // bypass for a write retiring in the same cycle the next read is issued
  logic                        fwd_valid;
  logic [31:0]                 fwd_data;

  logic                        in_xfer;
  logic                        mem_busy;
  logic [15:0]                 rd_addr;
  logic                        rd_in_range;
  logic [31:0]                 ram_q;
  logic [31:0]                 mem_word;
  logic [31:0]                 rd_word;
  acpu_pkg::mem_wr_t           wr;
  acpu_pkg::mem_wr_t           mem_wr;
  acpu_pkg::item_t             in_item;

  assign in_item = '{action:       action,
                     opcode:       opcode,
                     operand:      operand,
                     write_value:  write_value,
                     data_address: data_address};

  // stage 1 retires into the output register when that register is free or draining
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !mem_busy && (!s1_valid || s1_adv);
  assign in_xfer  = in_valid && in_ready;

  // read address: reads use data_address, everything else the operand
  assign rd_addr     = (action == acpu_pkg::ACT_READ) ? data_address : operand;
  assign rd_in_range = acpu_pkg::addr_in_range(rd_addr);

  // a write lands only in the cycle its item retires
  always_comb begin
    mem_wr    = wr;
    mem_wr.en = wr.en && s1_adv;
  end

  acpu_dmem u_dmem (
    .clk   (clk),
    .rst   (rst),
    .wr    (mem_wr),
    .re    (in_xfer),
    .raddr (rd_addr[acpu_pkg::ADDR_W-1:0]),
    .rdata (ram_q),
    .busy  (mem_busy)
  );

  // out-of-range words read as zero
  assign mem_word = !s1_in_range ? 32'd0 : (fwd_valid ? fwd_data : ram_q);

  acpu_exec u_exec (
    .state          (state),
    .item           (s1_item),
    .mem_word       (mem_word),
    .program_length (program_length),
    .state_next     (state_next),
    .read_data      (rd_word),
    .wr             (wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (config_write) begin
      program_length <= config_data;
    end
  end

  // stage 1 register; memory write is gated by s1_adv
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid  <= 1'b1;
        fwd_valid <= mem_wr.en && rd_in_range
                     && (wr.addr == rd_addr[acpu_pkg::ADDR_W-1:0]);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item     <= in_item;
      s1_in_range <= rd_in_range;
      fwd_data    <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      accumulator     <= state_next.acc;
      program_counter <= state_next.pc;
      zero_flag       <= state_next.z;
      carry_flag      <= state_next.c;
      negative_flag   <= state_next.n;
      overflow_flag   <= state_next.v;
      halted          <= state_next.halt;
      read_data       <= rd_word;
    end
  end

endmodule

### test/accumulator_cpu_step_checker.sv
`timescale 1ns / 100ps

module accumulator_cpu_step_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               config_write,
  input  logic [15:0]        config_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         action,
  input  logic [3:0]         opcode,
  input  logic [15:0]        operand,
  input  logic signed [31:0] write_value,
  input  logic [15:0]        data_address,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] accumulator,
  input  logic [15:0]        program_counter,
  input  logic               zero_flag,
  input  logic               carry_flag,
  input  logic               negative_flag,
  input  logic               overflow_flag,
  input  logic               halted,
  input  logic signed [31:0] read_data,
  output int                 errors,
  output int                 outstanding
);

  typedef struct packed {
    acpu_pkg::cpu_state_t st;
    logic [31:0]          rd;
  } cpu_result_t;

  logic [31:0]          data_mem [acpu_pkg::DATA_WORDS];
  acpu_pkg::cpu_state_t cpu;
  logic [15:0]          prog_len;
  cpu_result_t          pending_results [$];

  function automatic logic [31:0] mem_word(input logic [15:0] addr);
    if (int'(addr) < acpu_pkg::DATA_WORDS) return data_mem[addr[acpu_pkg::ADDR_W-1:0]];
    return '0;
  endfunction

  task automatic mem_store(input logic [15:0] addr, input logic [31:0] value);
    if (int'(addr) < acpu_pkg::DATA_WORDS) data_mem[addr[acpu_pkg::ADDR_W-1:0]] = value;
  endtask

  // advance the predicted core by one item, return the state it reports
  task automatic retire_item(input acpu_pkg::item_t it, output cpu_result_t res);
    logic [31:0] word;
    logic [31:0] sum;
    logic        carry;
    logic        touch_zn;
    touch_zn = 1'b0;
    res.rd = '0;
    case (it.action)
      acpu_pkg::ACT_EXEC: begin
        if (!cpu.halt) begin
          if (cpu.pc >= prog_len) begin
            cpu.halt = 1'b1;
          end else begin
            cpu.pc = cpu.pc + 16'd1;
            word = mem_word(it.operand);
            case (it.opcode)
              acpu_pkg::OP_LOAD: begin
                cpu.acc = word;
                touch_zn = 1'b1;
              end
              acpu_pkg::OP_STA: mem_store(it.operand, cpu.acc);
              acpu_pkg::OP_ADD: begin
                {carry, sum} = {1'b0, cpu.acc} + {1'b0, word};
                cpu.c = carry;
                cpu.v = (cpu.acc[31] == word[31]) && (sum[31] != cpu.acc[31]);
                cpu.acc = sum;
                touch_zn = 1'b1;
              end
              acpu_pkg::OP_SUB: begin
                cpu.c = $signed(word) > $signed(cpu.acc);
                cpu.v = 1'b0;
                cpu.acc = cpu.acc - word;
                touch_zn = 1'b1;
              end
              acpu_pkg::OP_MUL, acpu_pkg::OP_AND, acpu_pkg::OP_OR: begin
                if (it.opcode == acpu_pkg::OP_MUL) cpu.acc = cpu.acc * word;
                else if (it.opcode == acpu_pkg::OP_AND) cpu.acc = cpu.acc & word;
                else cpu.acc = cpu.acc | word;
                cpu.c = 1'b0;
                cpu.v = 1'b0;
                touch_zn = 1'b1;
              end
              acpu_pkg::OP_JMP: cpu.pc = it.operand;
              acpu_pkg::OP_HALT: cpu.halt = 1'b1;
              default: ;
            endcase
            if (touch_zn) begin
              cpu.z = (cpu.acc == '0);
              cpu.n = cpu.acc[31];
            end
          end
        end
      end
      acpu_pkg::ACT_WRITE: mem_store(it.data_address, it.write_value);
      acpu_pkg::ACT_READ: res.rd = mem_word(it.data_address);
      default: ;
    endcase
    res.st = cpu;
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    acpu_pkg::item_t it;
    cpu_result_t     want;
    if (rst) begin
      cpu = '0;
      prog_len = '0;
      errors = 0;
      pending_results.delete();
      foreach (data_mem[i]) data_mem[i] = '0;
      outstanding <= 0;
    end else begin
      // results first: an item accepted at this edge cannot be answered yet
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual acc %h pc %h",
                   $time, accumulator, program_counter);
          errors++;
        end else begin
          want = pending_results.pop_front();
          compare_field("accumulator", want.st.acc, accumulator);
          compare_field("program_counter", 32'(want.st.pc), 32'(program_counter));
          compare_field("zero_flag", 32'(want.st.z), 32'(zero_flag));
          compare_field("carry_flag", 32'(want.st.c), 32'(carry_flag));
          compare_field("negative_flag", 32'(want.st.n), 32'(negative_flag));
          compare_field("overflow_flag", 32'(want.st.v), 32'(overflow_flag));
          compare_field("halted", 32'(want.st.halt), 32'(halted));
          compare_field("read_data", want.rd, read_data);
        end
      end
      if (config_write) prog_len = config_data;
      if (in_valid && in_ready) begin
        it.action       = action;
        it.opcode       = opcode;
        it.operand      = operand;
        it.write_value  = write_value;
        it.data_address = data_address;
        retire_item(it, want);
        pending_results.push_back(want);
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

### test/accumulator_cpu_step_tb.sv
`timescale 1ns / 100ps

module accumulator_cpu_step_tb;

  localparam int IDLE_PCT     = 14;    // per-cycle idle chance on each side
  localparam int HOLD_CYCLES  = 200;   // one long receiver hold-off
  localparam int STALL_LIMIT  = 4000;  // above the clear sweep and the hold-off
  localparam int RANDOM_ITEMS = 1550;
  localparam int AFTER_HALT   = 60;

  // action with no meaning to the core, and the unassigned opcodes
  localparam logic [1:0] ACT_NONE    = 2'd3;
  localparam logic [3:0] OP_SPARE_LO = 4'd10;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               config_write = 1'b0;
  logic [15:0]        config_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         action = '0;
  logic [3:0]         opcode = '0;
  logic [15:0]        operand = '0;
  logic signed [31:0] write_value = '0;
  logic [15:0]        data_address = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] accumulator;
  logic [15:0]        program_counter;
  logic               zero_flag;
  logic               carry_flag;
  logic               negative_flag;
  logic               overflow_flag;
  logic               halted;
  logic signed [31:0] read_data;

  int errors;
  int outstanding;
  int idle_count = 0;

  // stimulus bookkeeping: where the PC will be, and the program length in force.
  // Halt is one-way with a single reset, so the PC is kept inside the program
  // until the very last phase.
  logic [15:0] pc_track = '0;
  logic [15:0] plen_track = '0;
  bit          after_halt = 1'b0;
  logic        calm = 1'b0;      // no idling on either side while high
  logic        hold_req = 1'b0;  // asks the receiver for its long hold-off

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  accumulator_cpu_step uut (
    .clk            (clk),
    .rst            (rst),
    .config_write   (config_write),
    .config_data    (config_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .opcode         (opcode),
    .operand        (operand),
    .write_value    (write_value),
    .data_address   (data_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accumulator    (accumulator),
    .program_counter(program_counter),
    .zero_flag      (zero_flag),
    .carry_flag     (carry_flag),
    .negative_flag  (negative_flag),
    .overflow_flag  (overflow_flag),
    .halted         (halted),
    .read_data      (read_data)
  );

  accumulator_cpu_step_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .config_write   (config_write),
    .config_data    (config_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .opcode         (opcode),
    .operand        (operand),
    .write_value    (write_value),
    .data_address   (data_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accumulator    (accumulator),
    .program_counter(program_counter),
    .zero_flag      (zero_flag),
    .carry_flag     (carry_flag),
    .negative_flag  (negative_flag),
    .overflow_flag  (overflow_flag),
    .halted         (halted),
    .read_data      (read_data),
    .errors         (errors),
    .outstanding    (outstanding)
  );

  // watchdog: any transfer on either channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_count <= 0;
    end else if (idle_count == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // result side: random back-pressure, plus one long hold-off so the
  // pipeline fills and in_ready drops while the sender keeps offering
  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // mostly a small pool so stores and reads hit the same words back to back
  function automatic logic [15:0] pick_addr();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return 16'($urandom_range(15));
    if (sel < 90) return 16'($urandom_range(acpu_pkg::DATA_WORDS - 1));
    return 16'($urandom_range(65535));
  endfunction

  // data words biased toward the carry and overflow corners
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'($urandom_range(4));
      default: return $urandom;
    endcase
  endfunction

  // one input transfer; called at a rising edge, returns at the accept edge
  task automatic push_item(input logic [1:0] act, input logic [3:0] op,
                           input logic [15:0] opnd, input logic [31:0] wval,
                           input logic [15:0] daddr);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    opcode       <= op;
    operand      <= opnd;
    write_value  <= wval;
    data_address <= daddr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act == acpu_pkg::ACT_EXEC) begin
      pc_track = (op == acpu_pkg::OP_JMP) ? opnd : pc_track + 16'd1;
    end
  endtask

  // drop valid and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] value);
    config_write <= 1'b1;
    config_data  <= value;
    @(posedge clk);
    config_write <= 1'b0;
    plen_track = value;
  endtask

  task automatic random_item();
    logic [3:0]  op;
    logic [15:0] opnd;
    int          pick;
    pick = $urandom_range(99);
    op   = 4'($urandom_range(15));
    opnd = pick_addr();
    if (pick < 55) begin
      if (!after_halt) begin
        // no HALT before the end, and a jump back whenever the next fetch
        // would fall off the program
        if (op == acpu_pkg::OP_HALT) op = acpu_pkg::OP_NOP;
        if (pc_track == plen_track - 16'd1) op = acpu_pkg::OP_JMP;
        if (op == acpu_pkg::OP_JMP) opnd = 16'($urandom_range(int'(plen_track) - 1));
      end
      push_item(acpu_pkg::ACT_EXEC, op, opnd, $urandom, pick_addr());
    end else if (pick < 80) begin
      push_item(acpu_pkg::ACT_WRITE, op, opnd, pick_word(), pick_addr());
    end else if (pick < 97) begin
      push_item(acpu_pkg::ACT_READ, op, opnd, $urandom, pick_addr());
    end else begin
      push_item(ACT_NONE, op, opnd, $urandom, pick_addr());
    end
  endtask

  initial begin : stimulus
    logic [15:0] next_len;
    int          n;
    n = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // program length zero: data side only, extremes and out-of-range words
    write_config(16'd0);
    push_item(acpu_pkg::ACT_WRITE, acpu_pkg::OP_NOP, 16'd0, 32'h7FFF_FFFF, 16'd0);
    push_item(acpu_pkg::ACT_WRITE, acpu_pkg::OP_NOP, 16'd0, 32'h0000_0001, 16'd1);
    push_item(acpu_pkg::ACT_WRITE, acpu_pkg::OP_NOP, 16'd0, 32'h8000_0000, 16'd2);
    push_item(acpu_pkg::ACT_WRITE, acpu_pkg::OP_NOP, 16'd0, 32'hFFFF_FFFF, 16'd3);
    push_item(acpu_pkg::ACT_WRITE, acpu_pkg::OP_NOP, 16'd0, 32'hA5A5_5A5A,
              16'(acpu_pkg::DATA_WORDS - 1));
    push_item(acpu_pkg::ACT_WRITE, acpu_pkg::OP_NOP, 16'd0, 32'h1234_5678,
              16'(acpu_pkg::DATA_WORDS));
    push_item(acpu_pkg::ACT_WRITE, acpu_pkg::OP_NOP, 16'd0, 32'hDEAD_BEEF, 16'hFFFF);
    push_item(acpu_pkg::ACT_READ, acpu_pkg::OP_NOP, 16'd0, 32'd0,
              16'(acpu_pkg::DATA_WORDS));
    push_item(acpu_pkg::ACT_READ, acpu_pkg::OP_NOP, 16'd0, 32'd0, 16'hFFFF);
    push_item(acpu_pkg::ACT_READ, acpu_pkg::OP_NOP, 16'd0, 32'd0,
              16'(acpu_pkg::DATA_WORDS - 1));
    push_item(ACT_NONE, acpu_pkg::OP_LOAD, 16'd0, 32'hFFFF_FFFF, 16'd0);
    drain();

    // full program length: every opcode but HALT, carry and overflow corners
    write_config(16'hFFFF);
    push_item(acpu_pkg::ACT_EXEC, acpu_pkg::OP_LOAD, 16'd0, 32'd0, 16'd0);
    push_item(acpu_pkg::ACT_EXEC, acpu_pkg::OP_ADD, 16'd1, 32'd0, 16'd0);  // signed overflow
    push_item(acpu_pkg::ACT_EXEC, acpu_pkg::OP_ADD, 16'd3, 32'd0, 16'd0);  // carry, overflow
    push_item(acpu_pkg::ACT_EXEC, acpu_pkg::OP_SUB, 16'd2, 32'd0, 16'd0);  // most negative
    push_item(acpu_pkg::ACT_EXEC, acpu_pkg::OP_SUB, 16'd0, 32'd0, 16'd0);  // above AC
    push_item(acpu_pkg::ACT_EXEC, acpu_pkg::OP_MUL, 16'd3, 32'd0, 16'd0);
    push_item(acpu_pkg::ACT_EXEC, acpu_pkg::OP_AND, 16'd2, 32'd0, 16'd0);
    push_item(acpu_pkg::ACT_EXEC, acpu_pkg::OP_OR, 16'd1, 32'd0, 16'd0);
    push_item(acpu_pkg::ACT_EXEC, acpu_pkg::OP_LOAD, 16'(acpu_pkg::DATA_WORDS + 88),
              32'd0, 16'd0);  // reads 0
    push_item(acpu_pkg::ACT_EXEC, acpu_pkg::OP_STA, 16'd5, 32'd0, 16'd0);
    push_item(acpu_pkg::ACT_READ, acpu_pkg::OP_NOP, 16'd0, 32'd0, 16'd5);  // behind the store
    push_item(acpu_pkg::ACT_EXEC, acpu_pkg::OP_STA, 16'hFFFF, 32'd0, 16'd0);  // dropped
    push_item(acpu_pkg::ACT_EXEC, acpu_pkg::OP_NOP, 16'd0, 32'd0, 16'd0);
    push_item(acpu_pkg::ACT_EXEC, OP_SPARE_LO, 16'd0, 32'd0, 16'd0);
    push_item(acpu_pkg::ACT_EXEC, OP_SPARE_HI, 16'hFFFF, 32'd0, 16'd0);
    push_item(acpu_pkg::ACT_EXEC, acpu_pkg::OP_JMP, 16'd40, 32'd0, 16'd0);
    push_item(acpu_pkg::ACT_WRITE, acpu_pkg::OP_NOP, 16'd0, 32'h0000_0003, 16'd6);
    push_item(acpu_pkg::ACT_READ, acpu_pkg::OP_NOP, 16'd0, 32'd0, 16'd6);
    push_item(acpu_pkg::ACT_EXEC, acpu_pkg::OP_ADD, 16'd6, 32'd0, 16'd0);

    // random phases under several program lengths
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: next_len = 16'hFFFF;
        1: next_len = 16'd1;
        2: next_len = 16'($urandom_range(64, 2));
        default: next_len = 16'($urandom_range(65535, 1000));
      endcase
      // land the PC inside the new program before switching
      push_item(acpu_pkg::ACT_EXEC, acpu_pkg::OP_JMP, 16'($urandom_range(int'(next_len) - 1)),
                $urandom, pick_addr());
      drain();
      write_config(next_len);
      for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
        if (n == 250) hold_req <= 1'b1;
        calm <= (n >= 600 && n < 900);
        random_item();
        n++;
      end
    end

    // stop the core, by HALT or by a fetch past the end of the program
    if ($urandom_range(1)) begin
      push_item(acpu_pkg::ACT_EXEC, acpu_pkg::OP_HALT, pick_addr(), $urandom, pick_addr());
    end else begin
      next_len = $urandom_range(1) ? 16'd0 : pc_track;
      drain();
      write_config(next_len);
      push_item(acpu_pkg::ACT_EXEC, 4'($urandom_range(15)), pick_addr(), $urandom,
                pick_addr());
    end

    // halted: execute items must change nothing, data side still works
    after_halt = 1'b1;
    repeat (AFTER_HALT) random_item();

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
